/* src/asc_pkg.sv */
// shared types, constants and command/status structs for the aliquot sum classifier
package asc_pkg;

	localparam int VALUE_WIDTH_DEF = 16;
	localparam int IN_W            = 16;
	localparam int SUM_OUT_W       = 18;
	localparam logic [SUM_OUT_W-1:0] SUM_MAX = 18'h3FFFF;

	localparam logic [1:0] CLASS_DEFICIENT = 2'd0;
	localparam logic [1:0] CLASS_PERFECT   = 2'd1;
	localparam logic [1:0] CLASS_ABUNDANT  = 2'd2;

	typedef struct packed {
		logic [IN_W-1:0] number_a;
		logic [IN_W-1:0] number_b;
	} in_item_t;

	typedef struct packed {
		logic [SUM_OUT_W-1:0] divisor_sum_a;
		logic [SUM_OUT_W-1:0] divisor_sum_b;
		logic [1:0]           number_class;
		logic                 is_amicable;
	} out_item_t;

	typedef struct packed {
		logic load_item;
		logic op_init;
		logic sel_b;
		logic div_start;
		logic div_step;
		logic acc;
		logic op_store;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic stop;
	} sts_t;

endpackage

/* src/aliquot_sum_classifier.sv */
// top level of the aliquot sum classifier
// Each transaction carries two numbers; for each, the proper divisor sum is found by trial
// division d = 1, 2, ... while d*d <= n, adding d and, if it differs, n/d for every divisor
// and subtracting n at the end. One restoring divider, shared by both numbers, yields one
// quotient bit per cycle. Items are handled one at a time; a finished result sits in an
// output register, so the next number pair can be taken while the previous result waits
// on res_ready.
module aliquot_sum_classifier #(
	parameter int VALUE_WIDTH = asc_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               num_valid,
	output logic               num_ready,
	input  asc_pkg::in_item_t  num,
	output logic               res_valid,
	input  logic               res_ready,
	output asc_pkg::out_item_t res
);
	import asc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	asc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_ready (num_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	asc_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

endmodule

/* src/asc_dp.sv */
// datapath: operand registers, shared restoring divider, divisor sum accumulator, result register
module asc_dp #(
	parameter int VALUE_WIDTH = asc_pkg::VALUE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  asc_pkg::in_item_t num,
	input  asc_pkg::cmd_t     cmd,
	output asc_pkg::sts_t     sts,
	output asc_pkg::out_item_t res
);
	import asc_pkg::*;

	localparam int W     = VALUE_WIDTH;
	localparam int SUM_W = VALUE_WIDTH + 3;
	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam int EXT_W = (W > IN_W) ? W : IN_W;
	localparam int CMP_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;

	logic [W-1:0]     a_q, b_q, n;
	logic [W-1:0]     d_q, quo_q, rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] total_q, sa_q, sb_q;
	logic [W:0]       shifted, trial;
	logic [SUM_W-1:0] q_term, d_term, op_sum;
	logic [EXT_W-1:0] a_ext, b_ext;
	logic [CMP_W-1:0] sa_wide, sb_wide;
	out_item_t        res_q;
	logic [1:0]       cls;

	// inputs are masked to the operand width
	assign a_ext = EXT_W'(num.number_a);
	assign b_ext = EXT_W'(num.number_b);

	assign n = cmd.sel_b ? b_q : a_q;

	// one quotient bit per cycle
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, d_q};

	assign sts.div_last = (cnt_q == CNT_W'(W - 1));
	// d*d > n exactly when d > floor(n/d)
	assign sts.stop     = (d_q > quo_q);

	assign d_term = (rem_q == '0) ? SUM_W'(d_q) : '0;
	assign q_term = (rem_q == '0 && quo_q != d_q) ? SUM_W'(quo_q) : '0;
	assign op_sum = total_q - SUM_W'(n);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			a_q <= a_ext[W-1:0];
			b_q <= b_ext[W-1:0];
		end
		if (cmd.div_start) begin
			quo_q <= n;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[W-2:0], ~trial[W]};
			rem_q <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
		end
		if (cmd.op_init) begin
			d_q     <= W'(1);
			total_q <= '0;
		end else if (cmd.acc) begin
			d_q     <= d_q + W'(1);
			total_q <= total_q + d_term + q_term;
		end
		if (cmd.op_store) begin
			if (cmd.sel_b) begin
				sb_q <= op_sum;
			end else begin
				sa_q <= op_sum;
			end
		end
		if (cmd.out_load) begin
			res_q.divisor_sum_a <= (sa_wide > CMP_W'(SUM_MAX)) ? SUM_MAX
				: sa_wide[SUM_OUT_W-1:0];
			res_q.divisor_sum_b <= (sb_wide > CMP_W'(SUM_MAX)) ? SUM_MAX
				: sb_wide[SUM_OUT_W-1:0];
			res_q.number_class  <= cls;
			res_q.is_amicable   <= (sa_q == SUM_W'(b_q)) && (sb_q == SUM_W'(a_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign sa_wide = CMP_W'(sa_q);
	assign sb_wide = CMP_W'(sb_q);

	always_comb begin
		priority if (sa_q < SUM_W'(a_q)) begin
			cls = CLASS_DEFICIENT;
		end else if (sa_q == SUM_W'(a_q)) begin
			cls = CLASS_PERFECT;
		end else begin
			cls = CLASS_ABUNDANT;
		end
	end

	assign res = res_q;

endmodule

/* src/asc_ctrl.sv */
// controller: sequences the trial divisions for both operands and the output handshake
module asc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          num_valid,
	output logic          num_ready,
	output logic          res_valid,
	input  logic          res_ready,
	input  asc_pkg::sts_t sts,
	output asc_pkg::cmd_t cmd
);
	import asc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_ACC   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0] state_q, state_d;
	logic       op_q, op_d;
	logic       out_valid_q;

	assign num_ready = (state_q == ST_IDLE);
	assign res_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		cmd           = '0;
		cmd.sel_b     = op_q;
		unique case (state_q)
			ST_IDLE: begin
				if (num_valid) begin
					cmd.load_item = 1'b1;
					cmd.op_init   = 1'b1;
					op_d          = 1'b0;
					state_d       = ST_START;
				end
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (sts.stop) begin
					cmd.op_store = 1'b1;
					if (!op_q) begin
						op_d        = 1'b1;
						cmd.op_init = 1'b1;
						state_d     = ST_START;
					end else begin
						state_d = ST_OUT;
					end
				end else begin
					cmd.acc = 1'b1;
					state_d = ST_START;
				end
			end
			ST_OUT: begin
				// previous transaction must have left the output register
				if (!out_valid_q || res_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result load did not raise valid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || res_ready))
		else $error("result register overwritten while held");

	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !sts.div_last) |=> (state_q == ST_DIV))
		else $error("division left before its last step");

	a_b_after_a: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && sts.stop && !op_q) |=> (op_q && state_q == ST_START))
		else $error("second operand not started after the first");

endmodule

/* test/aliquot_sum_classifier_test.sv */
// testbench for the aliquot sum classifier: directed and random number pairs checked against a divisor sum predictor
module aliquot_sum_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	import asc_pkg::*;

	localparam int SETTLE_CYCLES = 40;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       num_valid;
	logic       num_ready;
	in_item_t   num;
	logic       res_valid;
	logic       res_ready;
	out_item_t  res;

	out_item_t  pending_results[$];
	int         mismatch_count = 0;
	bit         idle_on = 1'b1;
	bit         stalls_on = 1'b1;

	int unsigned amicable_lo[8] = '{220, 1184, 2620, 5020, 6232, 10744, 12285, 17296};
	int unsigned amicable_hi[8] = '{284, 1210, 2924, 5564, 6368, 10856, 14595, 18416};
	int unsigned perfect_nums[4] = '{6, 28, 496, 8128};

	aliquot_sum_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_valid(num_valid),
		.num_ready(num_ready),
		.num      (num),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always #10 clk = ~clk;

	// exact sum of divisors d with 1 <= d <= n/2, by divisor pairs up to sqrt(n)
	function automatic longint unsigned aliquot_total(input longint unsigned n);
		longint unsigned total;
		longint unsigned d;
		total = 0;
		if (n < 2)
			return 0;
		for (d = 1; d * d <= n; d++) begin
			if (n % d == 0) begin
				total += d;
				if (n / d != d)
					total += n / d;
			end
		end
		return total - n;
	endfunction

	function automatic logic [SUM_OUT_W-1:0] clamp_sum(input longint unsigned s);
		return (s > longint'(SUM_MAX)) ? SUM_MAX : s[SUM_OUT_W-1:0];
	endfunction

	function automatic out_item_t classify_pair(input logic [IN_W-1:0] a_in, b_in);
		longint unsigned mask;
		longint unsigned a;
		longint unsigned b;
		longint unsigned sa;
		longint unsigned sb;
		out_item_t       r;
		mask = (64'd1 << VALUE_WIDTH_DEF) - 1;
		a = 64'(a_in) & mask;
		b = 64'(b_in) & mask;
		sa = aliquot_total(a);
		sb = aliquot_total(b);
		r.divisor_sum_a = clamp_sum(sa);
		r.divisor_sum_b = clamp_sum(sb);
		if (sa < a)
			r.number_class = CLASS_DEFICIENT;
		else if (sa == a)
			r.number_class = CLASS_PERFECT;
		else
			r.number_class = CLASS_ABUNDANT;
		r.is_amicable = (sa == b) && (sb == a);
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!idle_on || roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string field, input longint unsigned got, want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
		mismatch_count++;
	endtask

	task automatic send_numbers(input logic [IN_W-1:0] a, b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			num_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		num_valid <= 1'b1;
		num <= '{number_a: a, number_b: b};
		do @(posedge clk); while (!num_ready);
		pending_results.push_back(classify_pair(a, b));
	endtask

	// valid is dropped so the last pair is not taken again while waiting
	task automatic wait_until_drained();
		num_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic test_edges();
		send_numbers(16'd0, 16'd0);
		send_numbers(16'd1, 16'd0);
		send_numbers(16'd0, 16'd1);
		send_numbers(16'd1, 16'd1);
		send_numbers(16'd2, 16'd3);
		send_numbers(16'd12, 16'd18);
		send_numbers(16'd945, 16'd24);
		send_numbers(16'hFFFF, 16'hFFFF);
		send_numbers(16'hFFFE, 16'd65521);
		send_numbers(16'd55440, 16'd45360);
		send_numbers(16'hAAAA, 16'h5555);
		send_numbers(16'h5555, 16'hAAAA);
		send_numbers(16'hFFFF, 16'd0);
		send_numbers(16'd0, 16'hFFFF);
		send_numbers(16'h8000, 16'd1);
	endtask

	task automatic test_perfect_and_amicable();
		foreach (perfect_nums[i])
			send_numbers(IN_W'(perfect_nums[i]), IN_W'(perfect_nums[i]));
		send_numbers(16'd220, 16'd284);
		send_numbers(16'd284, 16'd220);
		send_numbers(16'd220, 16'd220);
		send_numbers(16'd17296, 16'd18416);
	endtask

	// mostly amicable pairs, some with b nudged by one so they are not amicable, some perfect pairs
	task automatic test_random_pairs(input int count);
		int          idx;
		logic [15:0] a;
		logic [15:0] b;
		repeat (count) begin
			idx = $urandom_range(0, 7);
			if ($urandom_range(0, 1)) begin
				a = 16'(amicable_lo[idx]);
				b = 16'(amicable_hi[idx]);
			end else begin
				a = 16'(amicable_hi[idx]);
				b = 16'(amicable_lo[idx]);
			end
			if ($urandom_range(0, 3) == 0)
				b = b + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
			else if ($urandom_range(0, 5) == 0) begin
				a = 16'(perfect_nums[$urandom_range(0, 3)]);
				b = a;
			end
			send_numbers(a, b);
		end
	endtask

	task automatic test_random_small(input int count);
		logic [15:0]     a;
		logic [15:0]     b;
		longint unsigned sa;
		repeat (count) begin
			a = 16'($urandom_range(0, 2047));
			sa = aliquot_total(64'(a));
			case ($urandom_range(0, 3))
				0: begin
					b = (sa <= 16'hFFFF) ? sa[15:0] : 16'($urandom_range(0, 2047));
				end
				1: begin
					b = a;
				end
				default: begin
					b = 16'($urandom_range(0, 2047));
				end
			endcase
			send_numbers(a, b);
		end
	endtask

	task automatic test_random_full(input int count);
		repeat (count)
			send_numbers(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
	endtask

	task automatic test_back_to_back(input int count);
		idle_on = 1'b0;
		stalls_on = 1'b0;
		test_random_small(count);
		idle_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	// result side: random stalls, each stall held for a gap length
	initial begin
		int  hold_left;
		bit  lowered;
		hold_left = 0;
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0)
				hold_left--;
			else begin
				lowered = stalls_on && arst_n && ($urandom_range(0, 3) == 0);
				res_ready <= arst_n && !lowered;
				if (lowered)
					hold_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$display("unexpected result transaction at %0t", $time);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (res.divisor_sum_a !== want.divisor_sum_a)
					report_mismatch("divisor_sum_a", 64'(res.divisor_sum_a),
						64'(want.divisor_sum_a));
				if (res.divisor_sum_b !== want.divisor_sum_b)
					report_mismatch("divisor_sum_b", 64'(res.divisor_sum_b),
						64'(want.divisor_sum_b));
				if (res.number_class !== want.number_class)
					report_mismatch("number_class", 64'(res.number_class),
						64'(want.number_class));
				if (res.is_amicable !== want.is_amicable)
					report_mismatch("is_amicable", 64'(res.is_amicable),
						64'(want.is_amicable));
			end
		end
	end

	// timeout, far longer than the slowest item takes
	initial begin
		#100_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		num_valid <= 1'b0;
		num <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		test_perfect_and_amicable();
		test_random_pairs(20);
		wait_until_drained();
		test_back_to_back(10);
		test_random_small(35);
		test_random_full(15);
		wait_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
